FILE: sv/pts_pkg.sv
// Package for per-task scheduler statistics: types, codes and constants.
`default_nettype none
package pts_pkg;

    localparam int TASKS_DEF = 4096;
    localparam int NCTR      = 13;
    localparam logic [6:0] WAIT_MASK = 7'h7f;

    // Event codes
    typedef enum logic [3:0] {
        OP_SWITCH   = 4'd0,
        OP_WAKE     = 4'd1,
        OP_NEW_WAKE = 4'd2,
        OP_WAIT     = 4'd3,
        OP_SLEEP    = 4'd4,
        OP_BLOCK    = 4'd5,
        OP_MIGRATE  = 4'd6,
        OP_FUTEX_IN = 4'd7,
        OP_FUTEX_OUT = 4'd8,
        OP_READ     = 4'd9
    } op_t;

    // Counter selects
    localparam logic [3:0] C_ONCPU = 4'd0;
    localparam logic [3:0] C_TOTAL = 4'd1;
    localparam logic [3:0] C_VOL   = 4'd2;
    localparam logic [3:0] C_INVOL = 4'd3;
    localparam logic [3:0] C_WAKE  = 4'd4;
    localparam logic [3:0] C_DSUM  = 4'd5;
    localparam logic [3:0] C_DMAX  = 4'd6;
    localparam logic [3:0] C_WAIT  = 4'd7;
    localparam logic [3:0] C_SLEEP = 4'd8;
    localparam logic [3:0] C_BLOCK = 4'd9;
    localparam logic [3:0] C_MIGR  = 4'd10;
    localparam logic [3:0] C_FTIME = 4'd11;
    localparam logic [3:0] C_FCNT  = 4'd12;

    typedef struct packed {
        logic [3:0]  operation;
        logic [11:0] task_id;
        logic [11:0] next_task_id;
        logic        prev_was_running;
        logic [63:0] timestamp;
        logic [63:0] delay_ns;
        logic [31:0] futex_op;
        logic [3:0]  counter_select;
    } in_t;

    typedef struct packed {
        logic [11:0] read_task;
        logic [3:0]  read_select;
        logic [63:0] counter_value;
    } out_t;

    // Per-task stamp word
    typedef struct packed {
        logic        wpend;
        logic [63:0] wstamp;
        logic        fpend;
        logic [63:0] fstamp;
    } tword_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TRD,
        S_TDAT,
        S_CRD,
        S_CWR,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        K_ADD,
        K_MAX,
        K_SET,
        K_READ
    } kind_t;

endpackage
`default_nettype wire

FILE: sv/pts_mem.sv
// Counter memory and per-task stamp memory, both with registered reads.
`default_nettype none
module pts_mem
    import pts_pkg::*;
#(
    parameter int TASKS = TASKS_DEF,
    parameter int CDEPTH = TASKS * NCTR,
    parameter int CAW = $clog2(CDEPTH),
    parameter int TIW = (TASKS > 1) ? $clog2(TASKS) : 1
)
(
    input  wire logic           clk,
    input  wire logic           cm_we,
    input  wire logic [CAW-1:0] cm_waddr,
    input  wire logic [63:0]    cm_wdata,
    input  wire logic [CAW-1:0] cm_raddr,
    output logic [63:0]         cm_rdata,
    input  wire logic           tm_we,
    input  wire logic [TIW-1:0] tm_waddr,
    input  wire tword_t         tm_wdata,
    input  wire logic [TIW-1:0] tm_raddr,
    output tword_t              tm_rdata
);

    logic [63:0] cmem [CDEPTH];
    tword_t      tmem [TASKS];

    // Counter memory port
    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cmem[cm_waddr] <= cm_wdata;
        end
        cm_rdata <= cmem[cm_raddr];
    end

    // Stamp memory port
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            tmem[tm_waddr] <= tm_wdata;
        end
        tm_rdata <= tmem[tm_raddr];
    end

endmodule
`default_nettype wire

FILE: sv/per_task_sched_stats_top.sv
// Top level of per-task scheduler statistics: event sequencer around the memories.
`default_nettype none
// Per-task scheduler accounting for one CPU.
// req carries one event (valid/ready); rsp returns one counter for each read
// request (valid/ready). Other requests return nothing.
// Requests are handled one at a time. Each passes from accept to ready again
// through a stamp memory read, then one step per counter (a read and a write
// for each read-modify-write, a single write for each cleared word), then a
// finish state. A switch touches up to 5 counters, a new wakeup clears all
// 13, most others touch one or two.
// Counters are visited one word per step through the counter memory.
// A read result sits in an output register; the next request is taken while
// it waits. If the receiver stalls, a second read holds in its finish cycle
// until the register frees.
// After reset the block clears its memories, one word a cycle, with req_ready
// low; running task and switch-in time reset to zero.
module per_task_sched_stats_top
    import pts_pkg::*;
#(
    parameter int TASKS = TASKS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire in_t  req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output out_t      rsp
);

    localparam int CDEPTH = TASKS * NCTR;
    localparam int CAW = $clog2(CDEPTH);
    localparam int TIW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int XW = (TIW > 12) ? TIW : 12;

    state_t         state_reg, state_next;
    in_t            req_reg, req_next;
    logic [3:0]     step_reg, step_next;
    tword_t         tw_reg, tw_next;
    logic [63:0]    don_reg, don_next;
    logic [63:0]    dwk_reg, dwk_next;
    logic [63:0]    dfx_reg, dfx_next;
    logic [11:0]    run_reg, run_next;
    logic [63:0]    sit_reg, sit_next;
    logic [CAW-1:0] clr_reg, clr_next;
    logic [63:0]    rdv_reg, rdv_next;
    out_t           out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic           cm_we;
    logic [CAW-1:0] cm_waddr, cm_raddr;
    logic [63:0]    cm_wdata, cm_rdata;
    logic           tm_we;
    logic [TIW-1:0] tm_waddr, tm_raddr;
    tword_t         tm_wdata, tm_rdata;

    pts_mem #(
        .TASKS(TASKS),
        .CDEPTH(CDEPTH),
        .CAW(CAW),
        .TIW(TIW)
    ) u_mem (
        .clk(clk),
        .cm_we(cm_we),
        .cm_waddr(cm_waddr),
        .cm_wdata(cm_wdata),
        .cm_raddr(cm_raddr),
        .cm_rdata(cm_rdata),
        .tm_we(tm_we),
        .tm_waddr(tm_waddr),
        .tm_wdata(tm_wdata),
        .tm_raddr(tm_raddr),
        .tm_rdata(tm_rdata)
    );

    // Request decode
    logic           use_t, use_n, charge, readable, is_read;
    logic [XW-1:0]  t_x, n_x;
    logic [TIW-1:0] tix, nix, six;
    op_t            op;

    assign op       = op_t'(req_reg.operation);
    assign use_t    = (req_reg.task_id != 12'd0) && (32'(req_reg.task_id) < TASKS);
    assign use_n    = (req_reg.next_task_id != 12'd0)
                      && (32'(req_reg.next_task_id) < TASKS);
    assign charge   = use_t && (req_reg.task_id == run_reg);
    assign readable = (32'(req_reg.task_id) < TASKS) && (req_reg.counter_select < 4'd13);
    assign is_read  = (op == OP_READ);
    assign t_x      = XW'(req_reg.task_id);
    assign n_x      = XW'(req_reg.next_task_id);
    assign tix      = t_x[TIW-1:0];
    assign nix      = n_x[TIW-1:0];

    // Step descriptor for the current counter step
    logic        s_act, s_done, s_next_task;
    logic [3:0]  s_sel;
    kind_t       s_kind;
    logic [63:0] s_opnd;

    always_comb
    begin
        s_act       = 1'b0;
        s_done      = 1'b1;
        s_next_task = 1'b0;
        s_sel       = C_ONCPU;
        s_kind      = K_ADD;
        s_opnd      = 64'd1;
        unique case (op)
            OP_SWITCH:
            begin
                s_done = (step_reg >= 4'd5);
                unique case (step_reg)
                    4'd0:
                    begin
                        s_act  = charge;
                        s_sel  = C_ONCPU;
                        s_opnd = don_reg;
                    end
                    4'd1:
                    begin
                        s_act = charge;
                        s_sel = C_TOTAL;
                    end
                    4'd2:
                    begin
                        s_act = charge;
                        s_sel = req_reg.prev_was_running ? C_INVOL : C_VOL;
                    end
                    4'd3:
                    begin
                        s_act       = use_n && tw_reg.wpend;
                        s_next_task = 1'b1;
                        s_sel       = C_DSUM;
                        s_opnd      = dwk_reg;
                    end
                    4'd4:
                    begin
                        s_act       = use_n && tw_reg.wpend;
                        s_next_task = 1'b1;
                        s_sel       = C_DMAX;
                        s_kind      = K_MAX;
                        s_opnd      = dwk_reg;
                    end
                    default:
                    begin
                        s_act = 1'b0;
                    end
                endcase
            end
            OP_WAKE:
            begin
                s_done = (step_reg >= 4'd1);
                s_act  = use_t;
                s_sel  = C_WAKE;
            end
            OP_NEW_WAKE:
            begin
                // zero the row; the wakeup count restarts at one
                s_done = (step_reg >= 4'd13);
                s_act  = use_t;
                s_sel  = step_reg;
                s_kind = K_SET;
                s_opnd = (step_reg == C_WAKE) ? 64'd1 : 64'd0;
            end
            OP_WAIT, OP_SLEEP, OP_BLOCK:
            begin
                s_done = (step_reg >= 4'd1);
                s_act  = use_t;
                s_sel  = (op == OP_WAIT) ? C_WAIT : ((op == OP_SLEEP) ? C_SLEEP : C_BLOCK);
                s_opnd = req_reg.delay_ns;
            end
            OP_MIGRATE:
            begin
                s_done = (step_reg >= 4'd1);
                s_act  = use_t;
                s_sel  = C_MIGR;
            end
            OP_FUTEX_OUT:
            begin
                s_done = (step_reg >= 4'd2);
                s_act  = use_t && tw_reg.fpend;
                s_sel  = (step_reg == 4'd0) ? C_FTIME : C_FCNT;
                s_opnd = (step_reg == 4'd0) ? dfx_reg : 64'd1;
            end
            OP_READ:
            begin
                s_done = (step_reg >= 4'd1);
                s_act  = 1'b1;
                s_sel  = req_reg.counter_select;
                s_kind = K_READ;
            end
            default:
            begin
                s_done = 1'b1;
            end
        endcase
    end

    // Counter word address: task * 13 + select
    logic [CAW-1:0] caddr;
    assign six   = s_next_task ? nix : tix;
    assign caddr = (CAW'(six) << 3) + (CAW'(six) << 2) + CAW'(six) + CAW'(s_sel);

    logic needs_rmw, fin_go;
    assign needs_rmw = s_act && ((s_kind == K_ADD) || (s_kind == K_MAX)
                       || ((s_kind == K_READ) && readable));
    assign fin_go    = !(is_read && out_valid_reg && !rsp_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CAW'(CDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_TRD;
                end
            end
            S_TRD:  state_next = S_TDAT;
            S_TDAT: state_next = S_CRD;
            S_CRD:
            begin
                if (s_done)
                begin
                    state_next = S_FIN;
                end
                else if (needs_rmw)
                begin
                    state_next = S_CWR;
                end
            end
            S_CWR:  state_next = S_CRD;
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        req_next       = req_reg;
        step_next      = step_reg;
        tw_next        = tw_reg;
        don_next       = don_reg;
        dwk_next       = dwk_reg;
        dfx_next       = dfx_reg;
        run_next       = run_reg;
        sit_next       = sit_reg;
        clr_next       = clr_reg;
        rdv_next       = rdv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cm_we          = 1'b0;
        cm_waddr       = caddr;
        cm_wdata       = s_opnd;
        cm_raddr       = caddr;
        tm_we          = 1'b0;
        tm_waddr       = (op == OP_SWITCH) ? nix : tix;
        tm_wdata       = tw_reg;
        tm_raddr       = (op == OP_SWITCH) ? nix : tix;
        req_ready      = (state_reg == S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                cm_we    = 1'b1;
                cm_waddr = clr_reg;
                cm_wdata = 64'd0;
                tm_we    = (32'(clr_reg) < TASKS);
                tm_waddr = clr_reg[TIW-1:0];
                tm_wdata = '0;
                clr_next = clr_reg + CAW'(1);
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                end
            end
            S_TRD:
            begin
                step_next = 4'd0;
            end
            S_TDAT:
            begin
                // stamp word arrives; precompute elapsed times
                tw_next  = tm_rdata;
                don_next = req_reg.timestamp - sit_reg;
                dwk_next = req_reg.timestamp - tm_rdata.wstamp;
                dfx_next = req_reg.timestamp - tm_rdata.fstamp;
            end
            S_CRD:
            begin
                if (!s_done && !needs_rmw)
                begin
                    step_next = step_reg + 4'd1;
                    if (s_act && (s_kind == K_SET))
                    begin
                        cm_we = 1'b1;
                    end
                    if (s_kind == K_READ)
                    begin
                        rdv_next = 64'd0;
                    end
                end
            end
            S_CWR:
            begin
                step_next = step_reg + 4'd1;
                unique case (s_kind)
                    K_ADD:
                    begin
                        cm_we    = 1'b1;
                        cm_wdata = cm_rdata + s_opnd;
                    end
                    K_MAX:
                    begin
                        cm_we    = 1'b1;
                        cm_wdata = (s_opnd > cm_rdata) ? s_opnd : cm_rdata;
                    end
                    K_READ:
                    begin
                        rdv_next = cm_rdata;
                    end
                    default:
                    begin
                        cm_we = 1'b0;
                    end
                endcase
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    // stamp word write-back
                    unique case (op)
                        OP_SWITCH:
                        begin
                            tm_we          = use_n && tw_reg.wpend;
                            tm_wdata.wpend = 1'b0;
                            run_next       = req_reg.next_task_id;
                            sit_next       = req_reg.timestamp;
                        end
                        OP_WAKE, OP_NEW_WAKE:
                        begin
                            tm_we           = use_t;
                            tm_wdata.wpend  = 1'b1;
                            tm_wdata.wstamp = req_reg.timestamp;
                        end
                        OP_FUTEX_IN:
                        begin
                            tm_we           = use_t
                                              && ((req_reg.futex_op[6:0] & WAIT_MASK) == 7'd0);
                            tm_wdata.fpend  = 1'b1;
                            tm_wdata.fstamp = req_reg.timestamp;
                        end
                        OP_FUTEX_OUT:
                        begin
                            tm_we          = use_t && tw_reg.fpend;
                            tm_wdata.fpend = 1'b0;
                        end
                        OP_READ:
                        begin
                            out_valid_next        = 1'b1;
                            out_next.read_task     = req_reg.task_id;
                            out_next.read_select   = req_reg.counter_select;
                            out_next.counter_value = rdv_reg;
                        end
                        default:
                        begin
                            tm_we = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                cm_we = 1'b0;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= 4'd0;
            run_reg       <= 12'd0;
            sit_reg       <= 64'd0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            run_reg       <= run_next;
            sit_reg       <= sit_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        tw_reg  <= tw_next;
        don_reg <= don_next;
        dwk_reg <= dwk_next;
        dfx_reg <= dfx_next;
        rdv_reg <= rdv_next;
        out_reg <= out_next;
    end

endmodule
`default_nettype wire

FILE: verif/per_task_sched_stats_top_tb.sv
// Testbench for per_task_sched_stats_top: random and directed events checked against a predictor.
`timescale 1ns / 1ps
module per_task_sched_stats_top_tb;
    import pts_pkg::*;

    // Scoreboard: predicts counters per task and checks read responses
    class sched_scoreboard;
        logic [63:0] counters [TASKS_DEF][NCTR];
        logic [63:0] wake_stamp [TASKS_DEF];
        bit          wake_pend [TASKS_DEF];
        logic [63:0] ftx_stamp [TASKS_DEF];
        bit          ftx_pend [TASKS_DEF];
        logic [11:0] cur_task;
        logic [63:0] cur_since;
        out_t        pending_reads[$];
        int          errors;

        function new();
            foreach (counters[i, j]) counters[i][j] = '0;
            foreach (wake_pend[i]) begin
                wake_pend[i] = 0;
                ftx_pend[i] = 0;
                wake_stamp[i] = '0;
                ftx_stamp[i] = '0;
            end
            cur_task = '0;
            cur_since = '0;
            errors = 0;
        endfunction

        // Apply one accepted request to the predicted state
        function void note_request(in_t r);
            bit ok;
            logic [63:0] d;
            out_t o;
            ok = (r.task_id != 0) && (r.task_id < TASKS_DEF);
            case (r.operation)
                OP_SWITCH:
                begin
                    if (r.task_id == cur_task && ok) begin
                        counters[r.task_id][C_ONCPU] += r.timestamp - cur_since;
                        counters[r.task_id][C_TOTAL] += 1;
                        if (r.prev_was_running)
                            counters[r.task_id][C_INVOL] += 1;
                        else
                            counters[r.task_id][C_VOL] += 1;
                    end
                    cur_task = r.next_task_id;
                    cur_since = r.timestamp;
                    if (r.next_task_id != 0 && wake_pend[r.next_task_id]) begin
                        d = r.timestamp - wake_stamp[r.next_task_id];
                        counters[r.next_task_id][C_DSUM] += d;
                        if (d > counters[r.next_task_id][C_DMAX])
                            counters[r.next_task_id][C_DMAX] = d;
                        wake_pend[r.next_task_id] = 0;
                    end
                end
                OP_WAKE, OP_NEW_WAKE:
                    if (ok) begin
                        wake_stamp[r.task_id] = r.timestamp;
                        wake_pend[r.task_id] = 1;
                        if (r.operation == OP_NEW_WAKE)
                            for (int k = 0; k < NCTR; k++) counters[r.task_id][k] = '0;
                        counters[r.task_id][C_WAKE] += 1;
                    end
                OP_WAIT:    if (ok) counters[r.task_id][C_WAIT] += r.delay_ns;
                OP_SLEEP:   if (ok) counters[r.task_id][C_SLEEP] += r.delay_ns;
                OP_BLOCK:   if (ok) counters[r.task_id][C_BLOCK] += r.delay_ns;
                OP_MIGRATE: if (ok) counters[r.task_id][C_MIGR] += 1;
                OP_FUTEX_IN:
                    if (ok && (r.futex_op[6:0] & WAIT_MASK) == 0) begin
                        ftx_stamp[r.task_id] = r.timestamp;
                        ftx_pend[r.task_id] = 1;
                    end
                OP_FUTEX_OUT:
                    if (ok && ftx_pend[r.task_id]) begin
                        counters[r.task_id][C_FTIME] += r.timestamp - ftx_stamp[r.task_id];
                        counters[r.task_id][C_FCNT] += 1;
                        ftx_pend[r.task_id] = 0;
                    end
                OP_READ:
                begin
                    o.read_task = r.task_id;
                    o.read_select = r.counter_select;
                    o.counter_value = (r.counter_select < NCTR) ?
                        counters[r.task_id][r.counter_select] : '0;
                    pending_reads.push_back(o);
                end
                default: ;
            endcase
        endfunction

        // Compare one response with the oldest predicted read
        function void check_response(out_t a);
            out_t e;
            if (pending_reads.size() == 0) begin
                $error("unexpected response task=%0d", a.read_task);
                errors++;
                return;
            end
            e = pending_reads.pop_front();
            if (a.read_task !== e.read_task) begin
                $error("read_task exp %0d got %0d", e.read_task, a.read_task);
                errors++;
            end
            if (a.read_select !== e.read_select) begin
                $error("read_select exp %0d got %0d", e.read_select, a.read_select);
                errors++;
            end
            if (a.counter_value !== e.counter_value) begin
                $error("counter_value exp %0h got %0h", e.counter_value, a.counter_value);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_ready;
    in_t  req = '0;
    logic rsp_valid;
    logic rsp_ready = 0;
    out_t rsp;

    sched_scoreboard sb;
    logic [63:0] now_ns = 64'd1000;
    bit no_idle = 0;
    bit hold_rsp = 0;
    bit stim_done = 0;
    logic [11:0] hot_tasks [8];

    always #4 clk = ~clk;

    per_task_sched_stats_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // Response monitor and scoreboard check
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
        if (rst_n && req_valid && req_ready)
            sb.note_request(req);
    end

    // Receiver: random stalls, long hold-off when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_rsp)
                rsp_ready <= 0;
            else if (no_idle)
                rsp_ready <= 1;
            else
                rsp_ready <= ($urandom_range(99) >= 22);
        end
    end

    // Send one request and wait for it to be accepted; valid drops only on idle cycles
    task automatic send_request(in_t r);
        if (!no_idle)
            while ($urandom_range(99) < 22) begin
                req_valid <= 0;
                @(negedge clk);
            end
        req <= r;
        req_valid <= 1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    function automatic in_t random_fields();
        in_t r;
        r.operation = OP_READ;
        r.task_id = 12'($urandom);
        r.next_task_id = 12'($urandom);
        r.prev_was_running = 1'($urandom);
        r.timestamp = {$urandom, $urandom};
        r.delay_ns = {$urandom, $urandom};
        r.futex_op = $urandom;
        r.counter_select = 4'($urandom);
        return r;
    endfunction

    function automatic logic [11:0] pick_task();
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'($urandom);
            default: return hot_tasks[$urandom_range(7)];
        endcase
    endfunction

    // Mostly plausible scheduler event stream over a few hot tasks
    function automatic in_t plausible_event();
        in_t r;
        int k;
        r = random_fields();
        now_ns += 64'($urandom_range(5000));
        if ($urandom_range(49) == 0) now_ns = {$urandom, $urandom};
        r.timestamp = now_ns;
        if ($urandom_range(3) != 0) r.delay_ns = 64'($urandom_range(100000));
        if ($urandom_range(1)) r.futex_op[6:0] = 0;
        k = $urandom_range(99);
        if (k < 25) begin
            r.operation = OP_SWITCH;
            r.task_id = ($urandom_range(4) != 0) ? sb.cur_task : pick_task();
            r.next_task_id = pick_task();
        end else if (k < 40) r.operation = OP_READ;
        else if (k < 42) r.operation = 4'($urandom_range(15, 10));
        else r.operation = 4'($urandom_range(8, 1));
        if (r.operation != OP_SWITCH) r.task_id = pick_task();
        return r;
    endfunction

    initial begin
        in_t r;
        sb = new();
        foreach (hot_tasks[i]) hot_tasks[i] = 12'($urandom_range(4095, 1));
        hot_tasks[0] = 12'd4095;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: every operation, field extremes, special cases
        r = random_fields();
        r.operation = OP_NEW_WAKE; r.task_id = 12'd4095; r.timestamp = 64'd100;
        send_request(r);
        r.operation = OP_SWITCH; r.task_id = 0; r.next_task_id = 12'd4095;
        r.timestamp = 64'd350; send_request(r);
        r.operation = OP_WAIT; r.task_id = 12'd4095; r.delay_ns = '1; send_request(r);
        r.operation = OP_SLEEP; r.delay_ns = 64'd7; send_request(r);
        r.operation = OP_BLOCK; r.delay_ns = 64'd3; send_request(r);
        r.operation = OP_MIGRATE; send_request(r);
        r.operation = OP_FUTEX_OUT; send_request(r);
        r.operation = OP_FUTEX_IN; r.futex_op = 32'hffffff80; r.timestamp = 64'd400;
        send_request(r);
        r.operation = OP_FUTEX_IN; r.futex_op = 32'h1; r.timestamp = 64'd450;
        send_request(r);
        r.operation = OP_FUTEX_OUT; r.timestamp = 64'd900; send_request(r);
        r.operation = OP_WAKE; r.task_id = 0; send_request(r);
        r.operation = 4'd15; r.task_id = 12'd4095; send_request(r);
        r.operation = OP_SWITCH; r.task_id = 12'd5; r.next_task_id = 0;
        send_request(r);
        r.operation = OP_SWITCH; r.task_id = 0; r.next_task_id = 12'd4095;
        send_request(r);
        r.operation = OP_SWITCH; r.task_id = 12'd4095; r.next_task_id = 12'd1;
        r.prev_was_running = 1; r.timestamp = '1; send_request(r);
        r.operation = OP_SWITCH; r.task_id = 12'd1; r.next_task_id = 12'd4095;
        r.prev_was_running = 0; r.timestamp = 64'd10; send_request(r);
        for (int s = 0; s < 16; s++) begin
            r.operation = OP_READ; r.task_id = (s == 15) ? 12'd0 : 12'd4095;
            r.counter_select = 4'(s);
            send_request(r);
        end

        // Random: bursts with no idling, then a long receiver hold-off
        for (int n = 0; n < 1700; n++) begin
            if (n == 300) no_idle = 1;
            if (n == 600) no_idle = 0;
            if (n == 900) begin
                r = plausible_event();
                r.operation = OP_READ;
                send_request(r);
                hold_rsp = 1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        hold_rsp = 0;
                    end
                join_none
            end
            if ($urandom_range(19) == 0) begin
                r = random_fields();
                r.operation = 4'($urandom_range(15));
            end else
                r = plausible_event();
            send_request(r);
        end
        req_valid <= 0;
        stim_done = 1;
    end

    // End of run: drain, settle, report
    initial begin
        wait (stim_done);
        while (sb.pending_reads.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("per_task_sched_stats_top_tb OK");
        else
            $display("per_task_sched_stats_top_tb NOT OK");
        $finish;
    end

    // Watchdog: clear pass plus worst-case items and stalls, with margin
    initial begin
        #(8ns * 4000000);
        $display("per_task_sched_stats_top_tb NOT OK");
        $finish;
    end
endmodule
